// File: src/psa_pkg.sv
package psa_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ReqW = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned DepthW = 7;
  localparam int unsigned StackDepthDef = 64;

  localparam logic [ReqW-1:0] REQ_PUSH = 3'd0;
  localparam logic [ReqW-1:0] REQ_ADD  = 3'd1;
  localparam logic [ReqW-1:0] REQ_SUB  = 3'd2;
  localparam logic [ReqW-1:0] REQ_MUL  = 3'd3;
  localparam logic [ReqW-1:0] REQ_DIV  = 3'd4;
  localparam logic [ReqW-1:0] REQ_NEG  = 3'd5;
  localparam logic [ReqW-1:0] REQ_READ = 3'd6;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_UNDER   = 2'd1;
  localparam logic [StatW-1:0] ST_FULL    = 2'd2;
  localparam logic [StatW-1:0] ST_DIVZERO = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT
  } cell_op_e;

  typedef struct packed {
    cell_op_e top_op;
    cell_op_e rest_op;
  } chain_ctrl_t;

  typedef struct packed {
    logic [ReqW-1:0]         req_type;
    logic signed [DataW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] top_value;
    logic                    top_valid;
    logic [StatW-1:0]        status;
    logic [DepthW-1:0]       depth;
  } res_t;

endpackage

// File: src/psa_cell.sv
module psa_cell (
  input  logic                         clk_i,
  input  psa_pkg::cell_op_e            op_i,
  input  logic [psa_pkg::DataW-1:0]    prev_i,
  input  logic [psa_pkg::DataW-1:0]    next_i,
  output logic [psa_pkg::DataW-1:0]    data_o
);

  logic [psa_pkg::DataW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      psa_pkg::CELL_TAKE_PREV: data_q <= prev_i;
      psa_pkg::CELL_TAKE_NEXT: data_q <= next_i;
      default:                 data_q <= data_q;
    endcase
  end

  assign data_o = data_q;

endmodule

// File: src/psa_div.sv
module psa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [psa_pkg::DataW-1:0]    dividend_i,
  input  logic [psa_pkg::DataW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [psa_pkg::DataW-1:0]    quotient_o
);

  localparam int unsigned W = psa_pkg::DataW;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] LastStep = CntW'(W - 1);

  logic            run_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q, quo_q, den_q;
  logic [W:0]      rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      den_q <= divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (run_q) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: src/postfix_stack_alu_unit.sv
// Channel   Ports                       Transfer
// request   start, busy, req_i          taken when start is high and busy is low
// result    done_o, res_o               one cycle on done_o, always taken
//
// Push, add, subtract, negate, read, errors: done_o is registered from S_CALC.
// Multiply: S_CALC registers the 32x32 product; done_o then comes from S_APPLY.
// Divide: the one-bit-per-cycle divider runs in S_DIV; done_o comes from S_APPLY.
// busy drops with done_o, so a new request may be taken in the result cycle.
// Reset clears the depth count; stack cells hold no reset value.
module postfix_stack_alu_unit #(
  parameter int unsigned STACK_DEPTH = psa_pkg::StackDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  psa_pkg::req_t req_i,
  output logic          done_o,
  output psa_pkg::res_t res_o
);

  localparam int unsigned W = psa_pkg::DataW;
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_APPLY
  } state_e;

  state_e                     state_q, state_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [psa_pkg::StatW-1:0]  status_q, status_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [psa_pkg::ReqW-1:0]   req_q;
  logic [W-1:0]               val_q, res_q, res_d;
  logic                       res_en;

  logic [W-1:0]               cell_data [STACK_DEPTH];
  logic [W-1:0]               load_val;
  psa_pkg::chain_ctrl_t       ctrl;

  logic [W-1:0]               op_a, op_b, prod, quot;
  logic                       div_start, div_done;
  logic                       accept;

  assign accept = start && !busy_q;
  assign op_b   = cell_data[0];
  assign op_a   = cell_data[1];
  assign prod   = op_a * op_b;

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    status_d  = status_q;
    count_d   = count_q;
    ctrl      = '{top_op: psa_pkg::CELL_HOLD, rest_op: psa_pkg::CELL_HOLD};
    load_val  = res_q;
    res_d     = res_q;
    res_en    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CALC;
          busy_d  = 1'b1;
        end
      end
      S_CALC: begin
        state_d  = S_IDLE;
        busy_d   = 1'b0;
        done_d   = 1'b1;
        status_d = psa_pkg::ST_OK;
        case (req_q)
          psa_pkg::REQ_PUSH: begin
            if (count_q == FullCnt) begin
              status_d = psa_pkg::ST_FULL;
            end else begin
              load_val = val_q;
              ctrl     = '{top_op: psa_pkg::CELL_TAKE_PREV, rest_op: psa_pkg::CELL_TAKE_PREV};
              count_d  = count_q + 1'b1;
            end
          end
          psa_pkg::REQ_ADD, psa_pkg::REQ_SUB, psa_pkg::REQ_MUL, psa_pkg::REQ_DIV: begin
            if (count_q == '0) begin
              status_d = psa_pkg::ST_UNDER;
            end else if (count_q == CntW'(1)) begin
              status_d = psa_pkg::ST_UNDER;
              count_d  = '0;
            end else if (req_q == psa_pkg::REQ_ADD || req_q == psa_pkg::REQ_SUB) begin
              load_val = (req_q == psa_pkg::REQ_ADD) ? (op_a + op_b) : (op_a - op_b);
              ctrl     = '{top_op: psa_pkg::CELL_TAKE_PREV, rest_op: psa_pkg::CELL_TAKE_NEXT};
              count_d  = count_q - 1'b1;
            end else if (req_q == psa_pkg::REQ_MUL) begin
              res_d   = prod;
              res_en  = 1'b1;
              state_d = S_APPLY;
              busy_d  = 1'b1;
              done_d  = 1'b0;
            end else if (op_b == '0) begin
              status_d = psa_pkg::ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
              busy_d    = 1'b1;
              done_d    = 1'b0;
            end
          end
          psa_pkg::REQ_NEG: begin
            if (count_q == '0) begin
              status_d = psa_pkg::ST_UNDER;
            end else begin
              load_val = '0 - op_b;
              ctrl     = '{top_op: psa_pkg::CELL_TAKE_PREV, rest_op: psa_pkg::CELL_HOLD};
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = quot;
          res_en  = 1'b1;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        load_val = res_q;
        ctrl     = '{top_op: psa_pkg::CELL_TAKE_PREV, rest_op: psa_pkg::CELL_TAKE_NEXT};
        count_d  = count_q - 1'b1;
        state_d  = S_IDLE;
        busy_d   = 1'b0;
        done_d   = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      status_q <= psa_pkg::ST_OK;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      busy_q   <= busy_d;
      done_q   <= done_d;
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.req_type;
      val_q <= req_i.push_value;
    end
    if (res_en) begin
      res_q <= res_d;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0] prev_w, next_w;
    if (i == 0) begin : g_top
      assign prev_w = load_val;
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end
    psa_cell u_cell (
      .clk_i  (clk_i),
      .op_i   ((i == 0) ? ctrl.top_op : ctrl.rest_op),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i])
    );
  end

  psa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (op_a),
    .divisor_i  (op_b),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign res_o.top_value = (count_q != '0) ? cell_data[0] : '0;
  assign res_o.top_valid = (count_q != '0);
  assign res_o.status    = status_q;
  assign res_o.depth     = psa_pkg::DepthW'(count_q);

endmodule
